// File: hw/rtl/video_unit_register_interface_assert.svh
// assertion helpers used by the checker module vuri_checker
`ifndef VIDEO_UNIT_REGISTER_INTERFACE_ASSERT_SVH
`define VIDEO_UNIT_REGISTER_INTERFACE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VURI_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define VURI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/vuri_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vuri_pkg;

  // sprite ram geometry
  localparam int OAM_BYTES = 256;
  localparam int OAM_AW    = $clog2(OAM_BYTES);

  // depth of the queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // item opcodes
  localparam logic [1:0] OP_CPU_RD = 2'd0;
  localparam logic [1:0] OP_CPU_WR = 2'd1;
  localparam logic [1:0] OP_DMA    = 2'd2;
  localparam logic [1:0] OP_EVENT  = 2'd3;

  // register numbers
  localparam logic [2:0] REG_CTRL     = 3'd0;
  localparam logic [2:0] REG_MASK     = 3'd1;
  localparam logic [2:0] REG_STATUS   = 3'd2;
  localparam logic [2:0] REG_OAM_ADDR = 3'd3;
  localparam logic [2:0] REG_OAM_DATA = 3'd4;
  localparam logic [2:0] REG_SCROLL   = 3'd5;
  localparam logic [2:0] REG_ADDR     = 3'd6;
  localparam logic [2:0] REG_DATA     = 3'd7;

  // video memory access codes
  localparam logic [1:0] VOP_NONE  = 2'd0;
  localparam logic [1:0] VOP_READ  = 2'd1;
  localparam logic [1:0] VOP_WRITE = 2'd2;

  // pointer steps and masks
  localparam logic [15:0] STEP_NARROW = 16'h0001;
  localparam logic [15:0] STEP_WIDE   = 16'h0020;
  localparam int          CTRL_INC_BIT = 2;
  localparam int          CTRL_NMI_BIT = 7;

  typedef struct packed {
    logic [1:0] opcode;
    logic [2:0] reg_index;
    logic [7:0] write_data;
    logic [7:0] vram_read_data;
    logic [7:0] oam_slot;
    logic       overflow_seen;
    logic       hit_seen;
    logic       frame_done;
  } in_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic [1:0]  vram_op;
    logic [13:0] vram_addr;
    logic [7:0]  vram_wdata;
    logic        nmi_request;
    logic [7:0]  scroll_x_out;
    logic [7:0]  scroll_y_out;
    logic [7:0]  control_out;
    logic [7:0]  mask_out;
  } out_t;

  // decoded command kinds
  typedef enum logic [3:0] {
    CMD_NOP_RD,
    CMD_STATUS_RD,
    CMD_OAM_RD,
    CMD_DATA_RD,
    CMD_LATCH_WR,
    CMD_CTRL_WR,
    CMD_MASK_WR,
    CMD_OAM_ADDR_WR,
    CMD_OAM_DATA_WR,
    CMD_SCROLL_WR,
    CMD_ADDR_WR,
    CMD_DATA_WR,
    CMD_DMA,
    CMD_EVENT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  data;
    logic [7:0]  vdata;
    logic [OAM_AW-1:0] slot;
    logic        ovf;
    logic        hit;
    logic        frame;
  } cmd_t;

endpackage

`default_nettype wire

// File: hw/rtl/vuri_front.sv
`timescale 1ns / 1ps
`default_nettype none

module vuri_front
  import vuri_pkg::*;
(
  input  in_t  item,
  output cmd_t cmd
);

  cmd_kind_t kind;

  always_comb begin
    kind = CMD_NOP_RD;
    case (item.opcode)
      OP_CPU_RD: begin
        case (item.reg_index)
          REG_STATUS:   kind = CMD_STATUS_RD;
          REG_OAM_DATA: kind = CMD_OAM_RD;
          REG_DATA:     kind = CMD_DATA_RD;
          default:      kind = CMD_NOP_RD;
        endcase
      end
      OP_CPU_WR: begin
        case (item.reg_index)
          REG_CTRL:     kind = CMD_CTRL_WR;
          REG_MASK:     kind = CMD_MASK_WR;
          REG_STATUS:   kind = CMD_LATCH_WR;
          REG_OAM_ADDR: kind = CMD_OAM_ADDR_WR;
          REG_OAM_DATA: kind = CMD_OAM_DATA_WR;
          REG_SCROLL:   kind = CMD_SCROLL_WR;
          REG_ADDR:     kind = CMD_ADDR_WR;
          REG_DATA:     kind = CMD_DATA_WR;
          default:      kind = CMD_LATCH_WR;
        endcase
      end
      OP_DMA:   kind = CMD_DMA;
      OP_EVENT: kind = CMD_EVENT;
      default:  kind = CMD_NOP_RD;
    endcase
  end

  // only the fields the back end needs travel on
  assign cmd.kind  = kind;
  assign cmd.data  = item.write_data;
  assign cmd.vdata = item.vram_read_data;
  assign cmd.slot  = item.oam_slot[OAM_AW-1:0];
  assign cmd.ovf   = item.overflow_seen;
  assign cmd.hit   = item.hit_seen;
  assign cmd.frame = item.frame_done;

endmodule

`default_nettype wire

// File: hw/rtl/vuri_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module vuri_queue
  import vuri_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  cmd_t          slot_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full       = (count_r == CW'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head_cmd   = slot_r[rd_ptr_r];

endmodule

`default_nettype wire

// File: hw/rtl/vuri_back.sv
`timescale 1ns / 1ps
`default_nettype none

module vuri_back
  import vuri_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic cmd_valid,
  input  cmd_t cmd,
  output logic cmd_pop,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  // architectural state
  logic [7:0]        ctrl_r, ctrl_nxt;
  logic [7:0]        mask_r, mask_nxt;
  logic              vblank_r, vblank_nxt;
  logic              hit_r, hit_nxt;
  logic              ovf_r, ovf_nxt;
  logic              toggle_r, toggle_nxt;
  logic [7:0]        scroll_x_r, scroll_x_nxt;
  logic [7:0]        scroll_y_r, scroll_y_nxt;
  logic [15:0]       vptr_r, vptr_nxt;
  logic [7:0]        rbuf_r, rbuf_nxt;
  logic [7:0]        latch_r, latch_nxt;
  logic              latch_ram_r, latch_ram_nxt;
  logic [OAM_AW-1:0] oam_ptr_r, oam_ptr_nxt;

  // sprite ram
  logic [7:0]        oam_mem [OAM_BYTES];
  logic [7:0]        ram_q_r;
  logic              ram_we, ram_re;
  logic [OAM_AW-1:0] ram_waddr;

  // result register
  logic              out_valid_r;
  out_t              out_r, out_nxt;
  logic              out_ram_r;

  logic              fire;
  logic [15:0]       step;
  logic [7:0]        latch_cur;
  logic [1:0]        vop;
  logic [13:0]       vaddr;
  logic [7:0]        vwdata;
  logic              nmi;

  assign fire      = cmd_valid && (!out_valid_r || !out_stall);
  assign cmd_pop   = fire;
  assign step      = ctrl_r[CTRL_INC_BIT] ? STEP_WIDE : STEP_NARROW;
  // latch may still be waiting in the sprite ram read register
  assign latch_cur = latch_ram_r ? ram_q_r : latch_r;

  always_comb begin
    ctrl_nxt      = ctrl_r;
    mask_nxt      = mask_r;
    vblank_nxt    = vblank_r;
    hit_nxt       = hit_r;
    ovf_nxt       = ovf_r;
    toggle_nxt    = toggle_r;
    scroll_x_nxt  = scroll_x_r;
    scroll_y_nxt  = scroll_y_r;
    vptr_nxt      = vptr_r;
    rbuf_nxt      = rbuf_r;
    latch_nxt     = latch_r;
    latch_ram_nxt = latch_ram_r;
    oam_ptr_nxt   = oam_ptr_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_waddr     = oam_ptr_r;
    vop           = VOP_NONE;
    vaddr         = '0;
    vwdata        = '0;
    nmi           = 1'b0;
    case (cmd.kind)
      CMD_NOP_RD: begin
      end
      CMD_STATUS_RD: begin
        latch_nxt     = {vblank_r, hit_r, ovf_r, latch_cur[4:0]};
        latch_ram_nxt = 1'b0;
        vblank_nxt    = 1'b0;
        toggle_nxt    = 1'b0;
      end
      CMD_OAM_RD: begin
        ram_re        = 1'b1;
        latch_ram_nxt = 1'b1;
      end
      CMD_DATA_RD: begin
        latch_nxt     = rbuf_r;
        latch_ram_nxt = 1'b0;
        rbuf_nxt      = cmd.vdata;
        vop           = VOP_READ;
        vaddr         = vptr_r[13:0];
        vptr_nxt      = vptr_r + step;
      end
      CMD_LATCH_WR: begin
        latch_nxt     = cmd.data;
        latch_ram_nxt = 1'b0;
      end
      CMD_CTRL_WR: begin
        latch_nxt     = cmd.data;
        latch_ram_nxt = 1'b0;
        ctrl_nxt      = cmd.data;
      end
      CMD_MASK_WR: begin
        latch_nxt     = cmd.data;
        latch_ram_nxt = 1'b0;
        mask_nxt      = cmd.data;
      end
      CMD_OAM_ADDR_WR: begin
        latch_nxt     = cmd.data;
        latch_ram_nxt = 1'b0;
        oam_ptr_nxt   = cmd.data[OAM_AW-1:0];
      end
      CMD_OAM_DATA_WR: begin
        latch_nxt     = cmd.data;
        latch_ram_nxt = 1'b0;
        ram_we        = 1'b1;
        oam_ptr_nxt   = oam_ptr_r + OAM_AW'(1);
      end
      CMD_SCROLL_WR: begin
        latch_nxt     = cmd.data;
        latch_ram_nxt = 1'b0;
        if (!toggle_r) begin
          scroll_x_nxt = cmd.data;
        end else begin
          scroll_y_nxt = cmd.data;
        end
        toggle_nxt    = !toggle_r;
      end
      CMD_ADDR_WR: begin
        latch_nxt     = cmd.data;
        latch_ram_nxt = 1'b0;
        if (!toggle_r) begin
          vptr_nxt = {cmd.data, vptr_r[7:0]};
        end else begin
          vptr_nxt = {vptr_r[15:8], cmd.data};
        end
        toggle_nxt    = !toggle_r;
      end
      CMD_DATA_WR: begin
        latch_nxt     = cmd.data;
        latch_ram_nxt = 1'b0;
        vop           = VOP_WRITE;
        vaddr         = vptr_r[13:0];
        vwdata        = cmd.data;
        vptr_nxt      = vptr_r + step;
      end
      CMD_DMA: begin
        ram_we        = 1'b1;
        ram_waddr     = cmd.slot;
      end
      CMD_EVENT: begin
        if (cmd.ovf) begin
          ovf_nxt = 1'b1;
        end
        if (cmd.hit) begin
          hit_nxt = 1'b1;
        end
        if (cmd.frame) begin
          vblank_nxt = 1'b1;
          hit_nxt    = 1'b0;
          nmi        = ctrl_r[CTRL_NMI_BIT];
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_nxt.read_data    = latch_nxt;
    out_nxt.vram_op      = vop;
    out_nxt.vram_addr    = vaddr;
    out_nxt.vram_wdata   = vwdata;
    out_nxt.nmi_request  = nmi;
    out_nxt.scroll_x_out = scroll_x_nxt;
    out_nxt.scroll_y_out = scroll_y_nxt;
    out_nxt.control_out  = ctrl_nxt;
    out_nxt.mask_out     = mask_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_r      <= '0;
      mask_r      <= '0;
      vblank_r    <= 1'b1;
      hit_r       <= 1'b0;
      ovf_r       <= 1'b0;
      toggle_r    <= 1'b0;
      scroll_x_r  <= '0;
      scroll_y_r  <= '0;
      vptr_r      <= '0;
      rbuf_r      <= '0;
      latch_r     <= '0;
      latch_ram_r <= 1'b0;
      oam_ptr_r   <= '0;
      out_valid_r <= 1'b0;
      out_ram_r   <= 1'b0;
    end else begin
      if (fire) begin
        ctrl_r      <= ctrl_nxt;
        mask_r      <= mask_nxt;
        vblank_r    <= vblank_nxt;
        hit_r       <= hit_nxt;
        ovf_r       <= ovf_nxt;
        toggle_r    <= toggle_nxt;
        scroll_x_r  <= scroll_x_nxt;
        scroll_y_r  <= scroll_y_nxt;
        vptr_r      <= vptr_nxt;
        rbuf_r      <= rbuf_nxt;
        latch_r     <= latch_nxt;
        latch_ram_r <= latch_ram_nxt;
        oam_ptr_r   <= oam_ptr_nxt;
        out_valid_r <= 1'b1;
        out_ram_r   <= latch_ram_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_r <= out_nxt;
    end
  end

  // sprite ram: one write and one registered read port
  always_ff @(posedge clk) begin
    if (fire && ram_we) begin
      oam_mem[ram_waddr] <= cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && ram_re) begin
      ram_q_r <= oam_mem[oam_ptr_r];
    end
  end

  always_comb begin
    out_data = out_r;
    if (out_ram_r) begin
      out_data.read_data = ram_q_r;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

// File: hw/rtl/video_unit_register_interface.sv
// register interface of a tile video unit
// in_* channel: one beat per cpu register read or write, oam dma byte or
//   renderer status event; in_data carries the whole item as one struct
// out_* channel: exactly one result beat per input beat, in order, with the
//   open-bus latch value, any video memory access the item causes, the nmi
//   request and the current scroll, control and mask bytes
// a beat moves on a rising edge where valid is high and stall is low
// path: a taken item is written into the command queue, then the execute
//   stage pops it from the queue head and loads the output register that
//   drives the result beat; a receiver stall can keep items queued
// throughput: one item per cycle sustained while unstalled, set by the
//   execute stage; sprite ram reads use its registered port, no bubble
// reset (rst_n low, synchronous): control, mask, scroll, pointers, buffer
//   and latch clear, vblank sets, the queue empties; sprite ram contents
//   stay undefined until written
// receiver stall: the result beat holds, execution pauses, the queue absorbs
//   up to QUEUE_DEPTH_P more beats and then in_stall rises
`timescale 1ns / 1ps
`default_nettype none

module video_unit_register_interface
  import vuri_pkg::*;
#(
  parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  // item channel
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_data,
  // result channel
  output logic out_valid,
  input  logic out_stall,
  output out_t out_data
);

  cmd_t front_cmd;   // decoded item from the front end
  cmd_t head_cmd;    // oldest queued command
  logic q_full;
  logic head_valid;
  logic head_pop;
  logic push;

  // accept whenever the queue has room
  assign push     = in_valid && !q_full;
  assign in_stall = q_full;

  // front: classify the item by opcode and register number
  vuri_front u_front (
    .item (in_data),
    .cmd  (front_cmd)
  );

  // queue decouples acceptance from execution
  vuri_queue #(
    .DEPTH (QUEUE_DEPTH_P)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (front_cmd),
    .full       (q_full),
    .pop        (head_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  // back: register state, sprite ram and result register
  vuri_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (head_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: hw/rtl/vuri_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "video_unit_register_interface_assert.svh"

module vuri_checker
  import vuri_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input in_t  in_data,
  input logic out_valid,
  input logic out_stall,
  input out_t out_data
);

  logic in_hold;
  logic out_hold;
  logic out_idle;
  logic vop_clear;
  logic out_wbyte;
  logic is_write;
  logic out_nmi;
  logic nmi_ok;

  assign in_hold   = in_valid && in_stall;
  assign out_hold  = out_valid && out_stall;
  assign out_idle  = out_valid && (out_data.vram_op == VOP_NONE);
  assign vop_clear = (out_data.vram_addr == '0) && (out_data.vram_wdata == '0);
  assign out_wbyte = out_valid && (out_data.vram_wdata != '0);
  assign is_write  = (out_data.vram_op == VOP_WRITE);
  assign out_nmi   = out_valid && out_data.nmi_request;
  assign nmi_ok    = out_data.control_out[CTRL_NMI_BIT] && (out_data.vram_op == VOP_NONE);

  // a stalled input beat stays put
  `VURI_ASSERT_NEXT(a_in_hold, in_hold, in_valid && $stable(in_data), "stalled input moved")

  // a stalled result beat stays put
  `VURI_ASSERT_NEXT(a_out_hold, out_hold, out_valid && $stable(out_data), "stalled result moved")

  // no access means no address and no write byte
  `VURI_ASSERT_NOW(a_vop_idle, out_idle, vop_clear, "address or data without an access")

  // write byte only on a data-port write
  `VURI_ASSERT_NOW(a_wdata_write, out_wbyte, is_write, "write byte without a write")

  // nmi only with nmi enabled and no video memory access
  `VURI_ASSERT_NOW(a_nmi_src, out_nmi, nmi_ok, "nmi without enable or with an access")

endmodule

bind video_unit_register_interface vuri_checker u_vuri_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire

// File: tb/sv/video_unit_register_interface_tb.sv
`timescale 1ns / 1ps

module video_unit_register_interface_tb;
  import vuri_pkg::*;

  localparam int RANDOM_BEATS = 950;
  localparam int CYCLE_LIMIT  = 40000;
  localparam int DRAIN_CYCLES = 8;
  localparam int IDLE_PCT     = 19;
  localparam int CALM_FROM    = 600;
  localparam int CALM_TO      = 900;
  localparam int HOLD_AT      = 250;
  localparam int HOLD_CYCLES  = 60;

  // one row of stimulus; fixed rows carry an expectation typed in by hand
  typedef struct {
    in_t  item;
    bit   fixed;
    out_t want;
  } stim_row_t;

  logic clk       = 1'b0;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  int cyc        = 0;
  int mismatches = 0;
  bit feed_done  = 1'b0;

  stim_row_t stim_rows[$];
  out_t      pending_results[$];

  // shadow copy of the register file, updated as each beat is taken
  logic [7:0]  ctrl_reg    = '0;
  logic [7:0]  mask_reg    = '0;
  logic        vblank      = 1'b1;
  logic        sprite_hit  = 1'b0;
  logic        sprite_ovf  = 1'b0;
  logic        second_write = 1'b0;
  logic [7:0]  scroll_h    = '0;
  logic [7:0]  scroll_v    = '0;
  logic [15:0] vram_ptr    = '0;
  logic [7:0]  data_buffer = '0;
  logic [7:0]  bus_value   = '0;
  logic [7:0]  oam_ptr     = '0;
  logic [7:0]  sprite_mem[OAM_BYTES];
  bit          sprite_known[OAM_BYTES];

  video_unit_register_interface u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // 2 ns period
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // cycle count, drives the calm window, the long hold and the timeout
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // no random idling on either side inside this window
  wire calm = (cyc >= CALM_FROM) && (cyc < CALM_TO);

  // pointer step picked by the increment bit of the control byte
  function automatic logic [15:0] ptr_step();
    return ctrl_reg[CTRL_INC_BIT] ? STEP_WIDE : STEP_NARROW;
  endfunction

  // advance the shadow registers by one beat and return the result it gives
  function automatic out_t step_registers(in_t it);
    out_t r;
    r = '0;
    case (it.opcode)
      OP_CPU_RD: begin
        case (it.reg_index)
          REG_STATUS: begin
            // flags land in the top three bits, low five keep the bus value
            bus_value    = {vblank, sprite_hit, sprite_ovf, bus_value[4:0]};
            vblank       = 1'b0;
            second_write = 1'b0;
          end
          REG_OAM_DATA: bus_value = sprite_mem[oam_ptr];
          REG_DATA: begin
            // buffered read: the bus gets last fetch, buffer gets this one
            bus_value   = data_buffer;
            data_buffer = it.vram_read_data;
            r.vram_op   = VOP_READ;
            r.vram_addr = vram_ptr[13:0];
            vram_ptr    = vram_ptr + ptr_step();
          end
          default: ;
        endcase
      end
      OP_CPU_WR: begin
        bus_value = it.write_data;
        case (it.reg_index)
          REG_CTRL:     ctrl_reg = it.write_data;
          REG_MASK:     mask_reg = it.write_data;
          REG_OAM_ADDR: oam_ptr  = it.write_data;
          REG_OAM_DATA: begin
            sprite_mem[oam_ptr]   = it.write_data;
            sprite_known[oam_ptr] = 1'b1;
            oam_ptr               = oam_ptr + 8'd1;
          end
          REG_SCROLL: begin
            if (!second_write) scroll_h = it.write_data;
            else scroll_v = it.write_data;
            second_write = ~second_write;
          end
          REG_ADDR: begin
            if (!second_write) vram_ptr[15:8] = it.write_data;
            else vram_ptr[7:0] = it.write_data;
            second_write = ~second_write;
          end
          REG_DATA: begin
            r.vram_op    = VOP_WRITE;
            r.vram_addr  = vram_ptr[13:0];
            r.vram_wdata = it.write_data;
            vram_ptr     = vram_ptr + ptr_step();
          end
          default: ;
        endcase
      end
      OP_DMA: begin
        sprite_mem[it.oam_slot]   = it.write_data;
        sprite_known[it.oam_slot] = 1'b1;
      end
      default: begin
        // hit is set first so a frame end in the same beat wins
        if (it.overflow_seen) sprite_ovf = 1'b1;
        if (it.hit_seen) sprite_hit = 1'b1;
        if (it.frame_done) begin
          vblank        = 1'b1;
          sprite_hit    = 1'b0;
          r.nmi_request = ctrl_reg[CTRL_NMI_BIT];
        end
      end
    endcase
    r.read_data    = bus_value;
    r.scroll_x_out = scroll_h;
    r.scroll_y_out = scroll_v;
    r.control_out  = ctrl_reg;
    r.mask_out     = mask_reg;
    return r;
  endfunction

  function automatic in_t mk(logic [1:0] op, logic [2:0] rsel, logic [7:0] data,
                             logic [7:0] vdata, logic [7:0] slot, logic [2:0] flags);
    in_t it;
    it.opcode         = op;
    it.reg_index      = rsel;
    it.write_data     = data;
    it.vram_read_data = vdata;
    it.oam_slot       = slot;
    it.overflow_seen  = flags[2];
    it.hit_seen       = flags[1];
    it.frame_done     = flags[0];
    return it;
  endfunction

  // beat with random video read data, sprite slot and event flags
  function automatic in_t beat(logic [1:0] op, logic [2:0] rsel, logic [7:0] data);
    return mk(op, rsel, data, 8'($urandom), 8'($urandom), 3'($urandom));
  endfunction

  // hand-typed expectation with no video memory access and no nmi
  function automatic out_t plain(logic [7:0] latch, logic [7:0] ctl, logic [7:0] msk);
    out_t r;
    r             = '0;
    r.read_data   = latch;
    r.control_out = ctl;
    r.mask_out    = msk;
    return r;
  endfunction

  task automatic add_row(in_t it, bit fixed, out_t want);
    stim_row_t row;
    row.item  = it;
    row.fixed = fixed;
    row.want  = want;
    stim_rows.insert(stim_rows.size(), row);
  endtask

  task automatic add(in_t it);
    add_row(it, 1'b0, '0);
  endtask

  // directed table: extremes, all registers written, flag corner cases
  task automatic build_directed();
    add_row(mk(OP_CPU_RD, REG_STATUS, 8'h00, 8'h00, 8'h00, 3'b000), 1'b1,
            plain(8'h80, 8'h00, 8'h00));
    add_row(mk(OP_CPU_RD, REG_STATUS, 8'hFF, 8'hFF, 8'hFF, 3'b111), 1'b1,
            plain(8'h00, 8'h00, 8'h00));
    add_row(mk(OP_CPU_WR, REG_STATUS, 8'hA5, 8'hFF, 8'hFF, 3'b111), 1'b1,
            plain(8'hA5, 8'h00, 8'h00));
    add_row(mk(OP_CPU_RD, REG_CTRL, 8'h00, 8'h00, 8'h00, 3'b000), 1'b1,
            plain(8'hA5, 8'h00, 8'h00));
    add_row(mk(OP_CPU_RD, REG_ADDR, 8'hFF, 8'hFF, 8'hFF, 3'b111), 1'b1,
            plain(8'hA5, 8'h00, 8'h00));
    add_row(mk(OP_CPU_WR, REG_CTRL, 8'h84, 8'h00, 8'h00, 3'b000), 1'b1,
            plain(8'h84, 8'h84, 8'h00));
    add_row(mk(OP_CPU_WR, REG_MASK, 8'hFF, 8'h00, 8'h00, 3'b000), 1'b1,
            plain(8'hFF, 8'h84, 8'hFF));
    // 14-bit window top, wide step past it, then a full 16-bit wrap
    add(mk(OP_CPU_WR, REG_ADDR, 8'h3F, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_WR, REG_ADDR, 8'hFF, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_WR, REG_DATA, 8'h5A, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_WR, REG_ADDR, 8'hFF, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_WR, REG_ADDR, 8'hFF, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_WR, REG_DATA, 8'h00, 8'hFF, 8'hFF, 3'b111));
    // buffered reads: first returns the old buffer
    add(mk(OP_CPU_RD, REG_DATA, 8'h00, 8'hFF, 8'h00, 3'b000));
    add(mk(OP_CPU_RD, REG_DATA, 8'hFF, 8'h00, 8'hFF, 3'b111));
    add(mk(OP_CPU_WR, REG_CTRL, 8'h00, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_WR, REG_SCROLL, 8'h00, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_WR, REG_SCROLL, 8'hFF, 8'h00, 8'h00, 3'b000));
    // sprite ram pointer wraps past the top byte
    add(mk(OP_CPU_WR, REG_OAM_ADDR, 8'hFF, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_WR, REG_OAM_DATA, 8'h11, 8'h00, 8'h00, 3'b000));
    add(mk(OP_DMA, REG_CTRL, 8'hFF, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_RD, REG_OAM_DATA, 8'h00, 8'h00, 8'hFF, 3'b000));
    // flags: sticky overflow, hit then frame end in one event, nmi
    add(mk(OP_EVENT, REG_CTRL, 8'h00, 8'h00, 8'h00, 3'b110));
    add(mk(OP_CPU_RD, REG_STATUS, 8'h00, 8'h00, 8'h00, 3'b000));
    add(mk(OP_CPU_WR, REG_CTRL, 8'h80, 8'h00, 8'h00, 3'b000));
    add(mk(OP_EVENT, REG_DATA, 8'hFF, 8'hFF, 8'hFF, 3'b011));
    add(mk(OP_CPU_RD, REG_STATUS, 8'h00, 8'h00, 8'h00, 3'b000));
  endtask

  // random part: mostly well-formed access sequences, some noise
  task automatic build_random();
    int n;
    int i;
    logic [7:0] base;
    while (stim_rows.size() < RANDOM_BEATS + 25) begin
      n = $urandom_range(1, 8);
      case ($urandom_range(9))
        0: begin
          // status read to clear the toggle, address pair, then data port
          add(beat(OP_CPU_RD, REG_STATUS, 8'($urandom)));
          add(beat(OP_CPU_WR, REG_ADDR, 8'($urandom)));
          add(beat(OP_CPU_WR, REG_ADDR, 8'($urandom)));
          for (i = 0; i < n; i++)
            add(beat(2'($urandom_range(OP_CPU_RD, OP_CPU_WR)), REG_DATA, 8'($urandom)));
        end
        1: begin
          if ($urandom_range(1)) add(beat(OP_CPU_RD, REG_STATUS, 8'($urandom)));
          add(beat(OP_CPU_WR, REG_SCROLL, 8'($urandom)));
          add(beat(OP_CPU_WR, REG_SCROLL, 8'($urandom)));
        end
        2: begin
          base = 8'($urandom);
          add(beat(OP_CPU_WR, REG_OAM_ADDR, base));
          for (i = 0; i < n; i++) add(beat(OP_CPU_WR, REG_OAM_DATA, 8'($urandom)));
          add(beat(OP_CPU_WR, REG_OAM_ADDR, base));
          for (i = 0; i < n; i++) add(beat(OP_CPU_RD, REG_OAM_DATA, 8'($urandom)));
        end
        3: begin
          base = 8'($urandom);
          for (i = 0; i < 4 * n; i++) begin
            add(mk(OP_DMA, 3'($urandom), 8'($urandom), 8'($urandom), base, 3'($urandom)));
            base = base + 8'd1;
          end
        end
        4: add(beat(OP_CPU_WR, REG_CTRL, 8'($urandom)));
        5: add(beat(OP_CPU_WR, REG_MASK, 8'($urandom)));
        6: begin
          for (i = 0; i < n; i++) add(beat(OP_EVENT, 3'($urandom), 8'($urandom)));
          add(beat(OP_CPU_RD, REG_STATUS, 8'($urandom)));
        end
        7, 8: begin
          for (i = 0; i < n; i++)
            add(beat(2'($urandom_range(OP_CPU_RD, OP_CPU_WR)), REG_DATA, 8'($urandom)));
        end
        default: add(beat(2'($urandom), 3'($urandom), 8'($urandom)));
      endcase
    end
  endtask

  task automatic compare_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %0h, actual %0h", $time, field, want, got);
      mismatches++;
    end
  endtask

  // sender: holds each beat until taken, predicts it on the taking edge
  initial begin : feed
    stim_row_t cur;
    out_t      predicted;
    bit        holding;
    holding = 1'b0;
    cur.fixed = 1'b0;
    build_directed();
    build_random();
    while (!rst_n) @(posedge clk);
    while (stim_rows.size() != 0 || holding) begin
      @(posedge clk);
      if (in_valid && !in_stall) begin
        predicted = step_registers(in_data);
        pending_results.insert(pending_results.size(), cur.fixed ? cur.want : predicted);
        holding = 1'b0;
      end
      if (!holding) begin
        if (stim_rows.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          cur = stim_rows.pop_front();
          // never read a sprite byte that was not written: write it instead
          if (cur.item.opcode == OP_CPU_RD && cur.item.reg_index == REG_OAM_DATA &&
              !sprite_known[oam_ptr])
            cur.item.opcode = OP_CPU_WR;
          in_data  <= cur.item;
          in_valid <= 1'b1;
          holding  = 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
    feed_done = 1'b1;
  end

  // receiver: random stalls, one long hold to back the block up
  initial begin : drain
    out_t want;
    int   hold_left;
    hold_left = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      @(posedge clk);
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $time, out_data);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          compare_field("read_data", 16'(want.read_data), 16'(out_data.read_data));
          compare_field("vram_op", 16'(want.vram_op), 16'(out_data.vram_op));
          compare_field("vram_addr", 16'(want.vram_addr), 16'(out_data.vram_addr));
          compare_field("vram_wdata", 16'(want.vram_wdata), 16'(out_data.vram_wdata));
          compare_field("nmi_request", 16'(want.nmi_request), 16'(out_data.nmi_request));
          compare_field("scroll_x_out", 16'(want.scroll_x_out), 16'(out_data.scroll_x_out));
          compare_field("scroll_y_out", 16'(want.scroll_y_out), 16'(out_data.scroll_y_out));
          compare_field("control_out", 16'(want.control_out), 16'(out_data.control_out));
          compare_field("mask_out", 16'(want.mask_out), 16'(out_data.mask_out));
        end
      end
      if (cyc == HOLD_AT) hold_left = HOLD_CYCLES;
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // reset, then wait for the last result and a short drain
  initial begin : run
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    while (!feed_done) @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/vuri_pkg.sv
hw/rtl/vuri_front.sv
hw/rtl/vuri_queue.sv
hw/rtl/vuri_back.sv
hw/rtl/video_unit_register_interface.sv
hw/rtl/vuri_checker.sv
tb/sv/video_unit_register_interface_tb.sv
